/* hdl/qwa_pkg.sv */
package qwa_pkg;

   // Width of one Q1.15 quaternion component.
   localparam int QW = 16;

   // Squared length threshold (Q2.30) below which a sample counts as near zero.
   localparam logic [63:0] NEAR_ZERO_SQ = 64'd10737419;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // One orientation sample as stored and carried between the parts.
   typedef struct packed {
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
      logic signed [QW-1:0] w;
   } quat_type;

endpackage

/* hdl/qwa_ram.sv */
module qwa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/qwa_queue.sv */
module qwa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[head_ff];

   // Pointer and count updates for each transfer.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[tail_ff] <= push_data;
      end
   end

endmodule

/* hdl/qwa_front.sv */
module qwa_front
   import qwa_pkg::*;
#(
   parameter int MAX_WINDOW = 16,
   parameter int SW         = 20,
   parameter int EW         = 209
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [4:0]                    csr_wr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  quat_type                      req_q,
   input  logic                          req_restart,
   output logic                          ent_push,
   output logic [EW-1:0]                 ent_data,
   input  logic                          ent_full,
   output logic                          ram_wr_en,
   output logic [$clog2(MAX_WINDOW)-1:0] ram_wr_addr,
   output quat_type                      ram_wr_data,
   output logic [$clog2(MAX_WINDOW)-1:0] ram_rd_addr,
   input  quat_type                      ram_rd_data
);

   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (LEN_W > 5) ? LEN_W : 5;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_READ = 3'b010,
      F_UPD  = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [4:0]        wl_ff;
   quat_type          q_ff, last_ff;
   logic [SLOT_W-1:0] slot_ff, slot_eff;
   logic [LEN_W-1:0]  fill_ff, len;
   logic signed [SW-1:0] sum_ff [4];
   logic signed [SW-1:0] sum_new [4];
   logic signed [QW-1:0] new_c [4];
   logic signed [QW-1:0] old_c [4];
   logic              accept, win_full, clear_hist, update;

   function automatic logic signed [SW-1:0] sext(input logic signed [QW-1:0] c);
      sext = {{(SW-QW){c[QW-1]}}, c};
   endfunction

   assign accept   = req_push && (state_ff == F_IDLE);
   assign req_full = (state_ff != F_IDLE);
   assign update   = (state_ff == F_UPD) && !ent_full;

   // Effective window length, clamped to 1..MAX_WINDOW.
   always_comb begin
      if (wl_ff == 5'd0) begin
         len = LEN_W'(1);
      end else if (CMP_W'(wl_ff) > CMP_W'(MAX_WINDOW)) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(wl_ff);
      end
   end

   assign slot_eff = (LEN_W'(slot_ff) >= len) ? '0 : slot_ff;
   assign win_full = (fill_ff >= len);

   // New running sums: drop the oldest sample when the window is full.
   assign new_c = '{q_ff.x, q_ff.y, q_ff.z, q_ff.w};
   assign old_c = '{ram_rd_data.x, ram_rd_data.y, ram_rd_data.z, ram_rd_data.w};
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_new[i] = sum_ff[i] + sext(new_c[i])
                      - (win_full ? sext(old_c[i]) : SW'(0));
      end
   end

   assign ram_rd_addr = slot_eff;
   assign ram_wr_addr = slot_eff;
   assign ram_wr_data = q_ff;
   assign ram_wr_en   = update;
   assign ent_push    = update;
   assign ent_data    = {q_ff, last_ff, sum_new[0], sum_new[1], sum_new[2], sum_new[3],
                         (len == LEN_W'(1))};

   assign clear_hist = csr_wr_en || (accept && req_restart);

   // Sequencer: accept, read the oldest entry, then update and hand off.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_READ;
         end
         F_READ: state_in = F_UPD;
         F_UPD: begin
            if (update) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         wl_ff    <= 5'd16;
         slot_ff  <= '0;
         fill_ff  <= '0;
         last_ff  <= '0;
         for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            wl_ff <= csr_wr_data;
         end
         if (clear_hist) begin
            slot_ff <= '0;
            fill_ff <= '0;
            last_ff <= '0;
            for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
         end else if (update) begin
            slot_ff <= (LEN_W'(slot_eff) + 1'b1 >= len) ? '0 : slot_eff + 1'b1;
            if (!win_full) fill_ff <= fill_ff + 1'b1;
            last_ff <= q_ff;
            for (int i = 0; i < 4; i++) sum_ff[i] <= sum_new[i];
         end
      end
   end

   // Captured sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff <= req_q;
      end
   end

endmodule

/* hdl/qwa_back.sv */
module qwa_back
   import qwa_pkg::*;
#(
   parameter int SW = 20,
   parameter int EW = 209
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [EW-1:0] ent_data,
   input  logic          ent_empty,
   output logic          ent_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output quat_type      rsp_q,
   output logic          rsp_passed_through
);

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_LSQ  = 7'b0000010,
      B_SSQ  = 7'b0000100,
      B_NORM = 7'b0001000,
      B_SQRT = 7'b0010000,
      B_DIV  = 7'b0100000,
      B_OUT  = 7'b1000000
   } back_state_type;

   back_state_type state_ff;
   quat_type       q_ff, last_ff, o_q, rsp_q_ff;
   logic signed [SW-1:0] sums_ff [4];
   logic signed [QW-1:0] last_c [4];
   logic signed [QW-1:0] o_ff [4];
   logic           len1_ff, o_pass_ff, rsp_valid_ff, rsp_pass_ff;
   logic [2:0]     cnt_ff;
   logic [1:0]     ci_ff;
   logic [63:0]    acc_ff, v_ff, res_ff, bit_ff, total, trial;
   logic [2*SW-1:0] prod_ff;
   logic [SW-1:0]  op;
   logic [4:0]     half_ff, dcnt_ff;
   logic [47:0]    num_ff;
   logic [48:0]    dv_ff;
   logic [16:0]    quo_ff;
   logic           load_rsp;

   function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] s);
      mag = s[SW-1] ? SW'(-s) : SW'(s);
   endfunction

   // Dividend for one component: |s| * 2^(16 + half) + r.
   function automatic logic [47:0] dividend(input logic signed [SW-1:0] s,
                                            input logic [4:0] h,
                                            input logic [63:0] r);
      logic [30:0] ash;
      ash = 31'({{31{1'b0}}, mag(s)} << h);
      dividend = {1'b0, ash, 16'd0} + 48'(r[31:0]);
   endfunction

   // Round-to-Q1.15 with saturation, sign taken from the sum.
   function automatic logic signed [QW-1:0] encode(input logic signed [SW-1:0] s,
                                                   input logic [16:0] m);
      logic [16:0] t;
      if (s[SW-1]) begin
         t = (m > 17'd32768) ? 17'd32768 : m;
         encode = QW'(17'h10000 - t);
      end else begin
         encode = (m > 17'd32767) ? 16'sd32767 : QW'(m);
      end
   endfunction

   assign last_c = '{last_ff.x, last_ff.y, last_ff.z, last_ff.w};

   // Operand of the shared squarer.
   always_comb begin
      if (state_ff == B_LSQ) begin
         op = SW'(mag(SW'(last_c[cnt_ff[1:0]])));
      end else begin
         op = mag(sums_ff[cnt_ff[1:0]]);
      end
   end

   assign total     = acc_ff + 64'(prod_ff);
   assign trial     = res_ff + bit_ff;
   assign ent_pop   = (state_ff == B_IDLE) && !ent_empty;
   assign load_rsp  = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_q     = rsp_q_ff;
   assign rsp_passed_through = rsp_pass_ff;
   assign o_q       = '{x: o_ff[0], y: o_ff[1], z: o_ff[2], w: o_ff[3]};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!ent_empty) state_ff <= B_LSQ;
            end
            B_LSQ: begin
               if (cnt_ff == 3'd4) begin
                  state_ff <= (total < NEAR_ZERO_SQ || len1_ff) ? B_OUT : B_SSQ;
               end
            end
            B_SSQ: begin
               if (cnt_ff == 3'd4) begin
                  state_ff <= (total == '0) ? B_OUT : B_NORM;
               end
            end
            B_NORM: begin
               if (v_ff >= 64'h1000_0000_0000_0000) state_ff <= B_SQRT;
            end
            B_SQRT: begin
               if (bit_ff == '0) state_ff <= B_DIV;
            end
            B_DIV: begin
               if (dcnt_ff == '0 && ci_ff == 2'd3) state_ff <= B_OUT;
            end
            B_OUT: begin
               if (load_rsp) state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // Datapath: squares, normalizing shift, square root and division.
   always_ff @(posedge clock) begin
      prod_ff <= op * op;
      case (state_ff)
         B_IDLE: begin
            {q_ff, last_ff, sums_ff[0], sums_ff[1], sums_ff[2], sums_ff[3], len1_ff}
               <= ent_data;
            cnt_ff <= '0;
            acc_ff <= '0;
         end
         B_LSQ, B_SSQ: begin
            if (cnt_ff == 3'd4) begin
               cnt_ff  <= '0;
               acc_ff  <= '0;
               v_ff    <= total;
               half_ff <= '0;
               if (state_ff == B_LSQ) begin
                  o_ff      <= '{q_ff.x, q_ff.y, q_ff.z, q_ff.w};
                  o_pass_ff <= 1'b1;
               end else begin
                  o_ff      <= '{default: '0};
                  o_pass_ff <= 1'b0;
               end
            end else begin
               if (cnt_ff != 3'd0) acc_ff <= total;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         B_NORM: begin
            if (v_ff < 64'h1000_0000_0000_0000) begin
               v_ff    <= v_ff << 2;
               half_ff <= half_ff + 1'b1;
            end else begin
               res_ff <= '0;
               bit_ff <= 64'h4000_0000_0000_0000;
            end
         end
         B_SQRT: begin
            if (bit_ff != '0) begin
               if (v_ff >= trial) begin
                  v_ff   <= v_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               ci_ff   <= 2'd0;
               num_ff  <= dividend(sums_ff[0], half_ff, res_ff);
               dv_ff   <= {res_ff[31:0], 17'd0};
               dcnt_ff <= 5'd17;
               quo_ff  <= '0;
            end
         end
         B_DIV: begin
            if (dcnt_ff != '0) begin
               if ({1'b0, num_ff} >= dv_ff) begin
                  num_ff <= 48'({1'b0, num_ff} - dv_ff);
                  quo_ff <= {quo_ff[15:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[15:0], 1'b0};
               end
               dv_ff   <= dv_ff >> 1;
               dcnt_ff <= dcnt_ff - 1'b1;
            end else begin
               o_ff[ci_ff] <= encode(sums_ff[ci_ff], quo_ff);
               ci_ff       <= ci_ff + 1'b1;
               num_ff      <= dividend(sums_ff[ci_ff + 1'b1], half_ff, res_ff);
               dv_ff       <= {res_ff[31:0], 17'd0};
               dcnt_ff     <= 5'd17;
               quo_ff      <= '0;
            end
         end
         B_OUT: begin
            if (load_rsp) begin
               rsp_q_ff    <= o_q;
               rsp_pass_ff <= o_pass_ff;
            end
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

endmodule

/* hdl/quaternion_window_average_unit.sv */
// Quaternion window average unit.
//
// Input channel: one orientation quaternion per transfer on req_in_x,
// req_in_y, req_in_z and req_in_w (Q1.15), with req_restart to clear the
// window first. A transfer happens when req_push is high and req_full is low.
// Result channel: the oldest result sits on rsp_out_x..rsp_out_w and
// rsp_passed_through while rsp_empty is low; it is taken when rsp_pop is high.
// Configuration: csr_wr_en writes csr_wr_data into the window length and
// clears the history; write it only while the unit is idle.
// The front part handles each item in order: accept, ring read, sum update.
// The back part takes a hand-off, the shared squarer on the previous sample
// and, for an averaged item, the squarer on the sums, normalizing shifts,
// the square root and the division of each component; both kinds end
// with an output step. Neither part takes a new item before it is
// through with the last one, and the serial square root and divider in
// the back part limit the throughput.
// A two-entry queue decouples the parts, and a result register lets the
// back part finish while the receiver stalls; it then waits in place.
// Reset clears the history, sets the window length to 16 and empties both
// channels.
module quaternion_window_average_unit
   import qwa_pkg::*;
#(
   parameter int MAX_WINDOW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   input  logic              req_push,
   output logic              req_full,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic signed [15:0] req_in_w,
   input  logic              req_restart,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic              rsp_passed_through
);

   localparam int SW     = QW + $clog2(MAX_WINDOW);
   localparam int EW     = 2 * $bits(quat_type) + 4 * SW + 1;
   localparam int SLOT_W = $clog2(MAX_WINDOW);

   quat_type          req_q, rsp_q, ram_wr_data, ram_rd_data;
   logic              ent_push, ent_full, ent_pop, ent_empty, ram_wr_en;
   logic [EW-1:0]     ent_in, ent_out;
   logic [SLOT_W-1:0] ram_wr_addr, ram_rd_addr;

   assign req_q     = '{x: req_in_x, y: req_in_y, z: req_in_z, w: req_in_w};
   assign rsp_out_x = rsp_q.x;
   assign rsp_out_y = rsp_q.y;
   assign rsp_out_z = rsp_q.z;
   assign rsp_out_w = rsp_q.w;

   // Front part: window bookkeeping.
   qwa_front #(.MAX_WINDOW(MAX_WINDOW), .SW(SW), .EW(EW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_q       (req_q),
      .req_restart (req_restart),
      .ent_push    (ent_push),
      .ent_data    (ent_in),
      .ent_full    (ent_full),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Sample ring.
   qwa_ram #(.WIDTH($bits(quat_type)), .DEPTH(MAX_WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Queue between the parts.
   qwa_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ent_push),
      .push_data (ent_in),
      .full      (ent_full),
      .pop       (ent_pop),
      .pop_data  (ent_out),
      .empty     (ent_empty)
   );

   // Back part: normalization.
   qwa_back #(.SW(SW), .EW(EW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .ent_data           (ent_out),
      .ent_empty          (ent_empty),
      .ent_pop            (ent_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_q              (rsp_q),
      .rsp_passed_through (rsp_passed_through)
   );

endmodule

/* dv/testbench.sv */
module testbench;

   localparam int WIN_MAX = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [63:0] NEAR_ZERO_LIMIT = 64'd10737419;

   // One input sample with its restart flag.
   typedef struct {
      logic signed [15:0] x, y, z, w;
      logic restart;
   } sample_type;

   // One averaged or passed-through orientation.
   typedef struct {
      logic signed [15:0] x, y, z, w;
      logic passed;
   } orient_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [4:0] csr_wr_data = 0;
   logic req_push = 0;
   logic req_full;
   logic signed [15:0] req_in_x = 0, req_in_y = 0, req_in_z = 0, req_in_w = 0;
   logic req_restart = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic rsp_passed_through;

   quaternion_window_average_unit dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_push(req_push), .req_full(req_full),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .req_in_w(req_in_w), .req_restart(req_restart),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_out_w(rsp_out_w), .rsp_passed_through(rsp_passed_through)
   );

   always #5 clock = ~clock;

   // Predictor state for the averaging window.
   logic signed [15:0] win_ring [WIN_MAX][4];
   int unsigned win_slot, win_fill;
   int signed win_sum [4];
   logic signed [15:0] prev_sample [4];
   logic [4:0] win_len_reg;

   sample_type pending_samples[$];
   orient_type expected_orients[$];
   bit failed = 0;
   bit calm = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0, recv_gap = 0;

   function automatic void clear_window();
      win_slot = 0;
      win_fill = 0;
      for (int i = 0; i < 4; i++) begin
         win_sum[i] = 0;
         prev_sample[i] = 0;
      end
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Work out the averaged orientation for one accepted sample.
   function automatic orient_type average_sample(sample_type s);
      orient_type o;
      logic signed [15:0] q [4];
      int unsigned len, half;
      logic [63:0] lsq, total, v, r, m, num;
      q[0] = s.x; q[1] = s.y; q[2] = s.z; q[3] = s.w;
      if (s.restart) clear_window();
      len = win_len_reg;
      if (len < 1) len = 1;
      if (len > WIN_MAX) len = WIN_MAX;
      lsq = 0;
      for (int i = 0; i < 4; i++)
         lsq += 64'(int'(prev_sample[i]) * int'(prev_sample[i]));
      if (win_slot >= len) win_slot = 0;
      if (win_fill >= len) begin
         for (int i = 0; i < 4; i++) win_sum[i] -= win_ring[win_slot][i];
      end else begin
         win_fill++;
      end
      for (int i = 0; i < 4; i++) begin
         win_ring[win_slot][i] = q[i];
         win_sum[i] += q[i];
         prev_sample[i] = q[i];
      end
      win_slot = (win_slot + 1 >= len) ? 0 : win_slot + 1;
      o.x = s.x; o.y = s.y; o.z = s.z; o.w = s.w;
      o.passed = 1;
      if (lsq < NEAR_ZERO_LIMIT || len == 1) return o;
      o.passed = 0;
      total = 0;
      for (int i = 0; i < 4; i++) begin
         m = (win_sum[i] < 0) ? 64'(-win_sum[i]) : 64'(win_sum[i]);
         total += m * m;
      end
      o.x = 0; o.y = 0; o.z = 0; o.w = 0;
      if (total == 0) return o;
      v = total;
      half = 0;
      while (v < (64'd1 << 60)) begin
         v <<= 2;
         half++;
      end
      r = root64(v);
      for (int i = 0; i < 4; i++) begin
         m = (win_sum[i] < 0) ? 64'(-win_sum[i]) : 64'(win_sum[i]);
         num = (m << (16 + half)) + r;
         m = num / (r << 1);
         if (win_sum[i] < 0) begin
            if (m > 32768) m = 32768;
            q[i] = 16'(17'h10000 - m);
         end else begin
            if (m > 32767) m = 32767;
            q[i] = m[15:0];
         end
      end
      o.x = q[0]; o.y = q[1]; o.z = q[2]; o.w = q[3];
      return o;
   endfunction

   // Driver: presents pending samples and predicts each accepted transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sample_type acc;
            acc.x = req_in_x; acc.y = req_in_y; acc.z = req_in_z; acc.w = req_in_w;
            acc.restart = req_restart;
            expected_orients.push_back(average_sample(acc));
            void'(pending_samples.pop_front());
         end
         if (req_push && !req_full || !req_push) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 0;
            end else if (!calm && $urandom_range(0, 19) == 0) begin
               send_gap = $urandom_range(1, 16);
               req_push <= 0;
            end else if (pending_samples.size() > 0) begin
               req_push <= 1;
               req_in_x <= pending_samples[0].x;
               req_in_y <= pending_samples[0].y;
               req_in_z <= pending_samples[0].z;
               req_in_w <= pending_samples[0].w;
               req_restart <= pending_samples[0].restart;
            end else begin
               req_push <= 0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            orient_type e;
            idle_cycles = 0;
            if (expected_orients.size() == 0) begin
               $error("result transfer with no expectation waiting");
               failed = 1;
            end else begin
               e = expected_orients.pop_front();
               if (rsp_out_x !== e.x) begin
                  $error("out_x expected %0d actual %0d", e.x, rsp_out_x); failed = 1;
               end
               if (rsp_out_y !== e.y) begin
                  $error("out_y expected %0d actual %0d", e.y, rsp_out_y); failed = 1;
               end
               if (rsp_out_z !== e.z) begin
                  $error("out_z expected %0d actual %0d", e.z, rsp_out_z); failed = 1;
               end
               if (rsp_out_w !== e.w) begin
                  $error("out_w expected %0d actual %0d", e.w, rsp_out_w); failed = 1;
               end
               if (rsp_passed_through !== e.passed) begin
                  $error("passed_through expected %0d actual %0d", e.passed,
                         rsp_passed_through);
                  failed = 1;
               end
            end
         end else if (!(req_push && !req_full)) begin
            idle_cycles++;
         end else begin
            idle_cycles = 0;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            recv_gap = $urandom_range(1, 16);
            rsp_pop <= 0;
         end else begin
            rsp_pop <= 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic sample_type unit_sample(logic restart);
      sample_type s;
      int sel;
      sel = $urandom_range(0, 9);
      s.x = 16'($urandom); s.y = 16'($urandom); s.z = 16'($urandom); s.w = 16'($urandom);
      if (sel < 6) begin
         // A noisy orientation near a common base keeps the averages meaningful.
         s.x = 16'sd9000 + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         s.y = -16'sd12000 + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         s.z = 16'sd20000 + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         s.w = 16'sd15000 + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      end else if (sel == 6) begin
         s.x = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
         s.y = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
         s.z = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
         s.w = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
      end
      s.restart = restart;
      return s;
   endfunction

   function automatic sample_type make_sample(int x, int y, int z, int w, logic restart);
      sample_type s;
      s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.w = 16'(w); s.restart = restart;
      return s;
   endfunction

   // Wait until the unit is idle, then change the window length.
   task automatic set_window(logic [4:0] len);
      while (pending_samples.size() > 0 || expected_orients.size() > 0 || req_push)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= len;
      win_len_reg = len;
      clear_window();
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   logic [4:0] phase_len [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd16};

   initial begin
      win_len_reg = 16;
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 0;
      // Directed samples: extremes, near-zero start, opposite pair and restart.
      pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 0));
      pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, 0));
      pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, 0));
      pending_samples.push_back(make_sample(16384, 0, 0, 0, 1));
      pending_samples.push_back(make_sample(-16384, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 0, 0, 32767, 0));
      pending_samples.push_back(make_sample(0, 0, 0, 32767, 0));
      pending_samples.push_back(make_sample(3276, 0, 0, 0, 1));
      pending_samples.push_back(make_sample(3276, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(3277, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 0, 0, 1, 0));
      pending_samples.push_back(make_sample(-32768, 32767, -1, 1, 0));
      pending_samples.push_back(make_sample(21845, -21846, 1, -2, 0));
      for (int i = 0; i < 10; i++) pending_samples.push_back(unit_sample(i == 0));
      // Random phases across several window lengths.
      foreach (phase_len[p]) begin
         set_window(phase_len[p]);
         if (p == 7) calm = 1;
         for (int i = 0; i < 190; i++)
            pending_samples.push_back(unit_sample($urandom_range(0, 39) == 0));
      end
      while (pending_samples.size() > 0 || expected_orients.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_orients.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
